// File: src/audio_ring_double_buffer_refill_top_macros.svh
// Assertion macros for the audio ring double buffer refill block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef AUDIO_RING_DOUBLE_BUFFER_REFILL_TOP_MACROS_SVH
`define AUDIO_RING_DOUBLE_BUFFER_REFILL_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle
`define ARDB_ASSERT_IMP(LBL, CLK, RSTN, A, C, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |-> (C)) else $error(MSG);

// Check that a condition implies another in the next cycle
`define ARDB_ASSERT_NXT(LBL, CLK, RSTN, A, C, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |=> (C)) else $error(MSG);

`endif

// File: src/ardb_pkg.sv
// Shared constants and types for the audio ring double buffer refill block.
// No dependencies; imported by the refill engine and the top level.
package ardb_pkg;

	// Geometry of the ring and the two-half play buffer
	localparam int HALF_LENGTH = 315;
	localparam int RING_DEPTH  = 512;
	localparam int PLAY_LENGTH = 2 * HALF_LENGTH;
	localparam int RING_AW     = $clog2(RING_DEPTH);
	localparam int PLAY_AW     = $clog2(PLAY_LENGTH);
	localparam int LEVEL_W     = 9;

	localparam logic [7:0] SILENCE_BYTE = 8'h80;

	// Input command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Refill request from the top level to the refill engine
	typedef struct packed {
		logic               start;
		logic [PLAY_AW-1:0] base;
		logic [RING_AW-1:0] ptr;
		logic [RING_AW-1:0] cnt;
	} fill_req_t;

endpackage

// File: src/ardb_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module ardb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/ardb_refill.sv
// Refill engine: clears the play buffer after reset and copies one half from the ring, padding with silence.
// Depends on ardb_pkg and the assertion macro header.
`include "audio_ring_double_buffer_refill_top_macros.svh"

module ardb_refill
	import ardb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  fill_req_t          req,
	input  logic [7:0]         ring_rdata,
	output logic               busy,
	output logic               ring_re,
	output logic [RING_AW-1:0] ring_raddr,
	output logic               play_we,
	output logic [PLAY_AW-1:0] play_waddr,
	output logic [7:0]         play_wdata
);

	typedef enum logic [2:0] {
		F_CLEAR = 3'b001,
		F_IDLE  = 3'b010,
		F_COPY  = 3'b100
	} fill_state_t;

	fill_state_t        state_q;
	logic [PLAY_AW-1:0] idx_q;
	logic [PLAY_AW-1:0] base_q;
	logic [RING_AW-1:0] ptr_q;
	logic [RING_AW-1:0] left_q;
	logic               wr_s1;
	logic               from_ring_s1;
	logic [PLAY_AW-1:0] waddr_s1;
	logic [RING_AW-1:0] ptr_nxt;

	// Read the ring while drained samples remain
	assign ring_re    = (state_q == F_COPY) && (left_q != '0);
	assign ring_raddr = ptr_q;
	assign ptr_nxt    = (ptr_q == RING_AW'(RING_DEPTH - 1)) ? '0 : ptr_q + RING_AW'(1);

	// Sequence clear and copy passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_CLEAR;
			idx_q   <= '0;
			wr_s1   <= 1'b0;
		end else begin
			wr_s1 <= (state_q == F_COPY);
			case (state_q)
				F_CLEAR: begin
					if (idx_q == PLAY_AW'(PLAY_LENGTH - 1)) begin
						idx_q   <= '0;
						state_q <= F_IDLE;
					end else begin
						idx_q <= idx_q + PLAY_AW'(1);
					end
				end
				F_IDLE: begin
					if (req.start) begin
						idx_q   <= '0;
						state_q <= F_COPY;
					end
				end
				F_COPY: begin
					if (idx_q == PLAY_AW'(HALF_LENGTH - 1)) begin
						idx_q   <= '0;
						state_q <= F_IDLE;
					end else begin
						idx_q <= idx_q + PLAY_AW'(1);
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Capture the request and advance the ring read pointer
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && req.start) begin
			base_q <= req.base;
			ptr_q  <= req.ptr;
			left_q <= req.cnt;
		end else if (ring_re) begin
			ptr_q  <= ptr_nxt;
			left_q <= left_q - RING_AW'(1);
		end
		from_ring_s1 <= ring_re;
		waddr_s1     <= base_q + idx_q;
	end

	// Drive the play buffer write port: silence sweep or delayed copy
	always_comb begin
		if (state_q == F_CLEAR) begin
			play_we    = 1'b1;
			play_waddr = idx_q;
			play_wdata = SILENCE_BYTE;
		end else begin
			play_we    = wr_s1;
			play_waddr = waddr_s1;
			play_wdata = from_ring_s1 ? ring_rdata : SILENCE_BYTE;
		end
	end

	assign busy = (state_q != F_IDLE) || wr_s1;

	`ARDB_ASSERT_IMP(a_copy_idx_range, clk, arst_n, state_q == F_COPY, idx_q < PLAY_AW'(HALF_LENGTH), "copy index past half")
	`ARDB_ASSERT_IMP(a_start_when_idle, clk, arst_n, req.start, state_q == F_IDLE, "refill started while busy")
	`ARDB_ASSERT_NXT(a_ring_data_used, clk, arst_n, ring_re, wr_s1 && from_ring_s1, "ring read not written back")

endmodule

// File: src/audio_ring_double_buffer_refill_top.sv
// A word is accepted only in ST_IDLE; its result waits in ST_POST until the output register
// takes it, and no new word is accepted before that. A tick that ends a half then stalls
// input while the refill engine copies that half from the ring RAM, one byte per cycle
// through the play RAM port. Reset: pointers clear at once; a silence sweep then fills
// all PLAY_LENGTH (630) play RAM entries while input is stalled.
// Top level: command decode, ring pointers, memories, refill engine and output register.
`include "audio_ring_double_buffer_refill_top_macros.svh"

module audio_ring_double_buffer_refill_top
	import ardb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [7:0]         sample_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         sample_out,
	output logic               write_accepted,
	output logic               half_refilled,
	output logic               underrun,
	output logic [LEVEL_W-1:0] ring_level
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_POST = 2'b10
	} top_state_t;

	top_state_t         state_q;
	logic [RING_AW-1:0] head_q;
	logic [RING_AW-1:0] tail_q;
	logic [PLAY_AW-1:0] pos_q;
	logic               half_q;

	logic               res_tick_q;
	logic               res_acc_q;
	logic               res_ref_q;
	logic               res_pad_q;
	logic [PLAY_AW-1:0] req_base_q;
	logic [RING_AW-1:0] req_ptr_q;
	logic [RING_AW-1:0] req_cnt_q;

	logic               out_valid_q;
	logic [7:0]         sample_out_q;
	logic               write_accepted_q;
	logic               half_refilled_q;
	logic               underrun_q;
	logic [LEVEL_W-1:0] ring_level_q;

	logic                 accept;
	logic                 out_load;
	logic                 fill_busy;
	fill_req_t            fill_req;
	logic [RING_AW-1:0]   head_nxt;
	logic                 ring_full;
	logic [RING_AW-1:0]   ring_cnt;
	logic [RING_AW:0]     cnt_wrap;
	logic [LEVEL_W-1:0]   cnt_ext;
	logic                 ring_we;
	logic                 ring_re;
	logic [RING_AW-1:0]   ring_raddr;
	logic [7:0]           ring_rdata;
	logic                 play_we;
	logic [PLAY_AW-1:0]   play_waddr;
	logic [7:0]           play_wdata;
	logic                 play_re;
	logic [7:0]           play_rdata;
	logic [PLAY_AW:0]     pos_inc;
	logic                 at_half;
	logic                 at_end;
	logic                 refill;
	logic                 pad;
	logic [RING_AW-1:0]   drain;
	logic [RING_AW:0]     tail_sum;
	logic [RING_AW-1:0]   tail_new;
	logic [PLAY_AW-1:0]   base;

	// Handshake
	assign in_stall = (state_q != ST_IDLE) || fill_busy;
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == ST_POST) && (!out_valid_q || !out_stall);

	// Ring occupancy and full test
	assign head_nxt  = (head_q == RING_AW'(RING_DEPTH - 1)) ? '0 : head_q + RING_AW'(1);
	assign ring_full = (head_nxt == tail_q);
	assign cnt_wrap  = {1'b0, head_q} + (RING_AW+1)'(RING_DEPTH) - {1'b0, tail_q};
	assign ring_cnt  = (head_q >= tail_q) ? (head_q - tail_q) : cnt_wrap[RING_AW-1:0];
	assign cnt_ext   = LEVEL_W'(ring_cnt);

	// Play position and half boundary
	assign pos_inc = {1'b0, pos_q} + (PLAY_AW+1)'(1);
	assign at_half = (pos_inc == (PLAY_AW+1)'(HALF_LENGTH));
	assign at_end  = (pos_inc == (PLAY_AW+1)'(PLAY_LENGTH));
	assign refill  = at_half || at_end;

	// Drain amount and the tail after the refill
	assign pad      = (32'(ring_cnt) < HALF_LENGTH);
	assign drain    = pad ? ring_cnt : RING_AW'(HALF_LENGTH);
	assign tail_sum = {1'b0, tail_q} + {1'b0, drain};
	assign tail_new = (tail_sum >= (RING_AW+1)'(RING_DEPTH)) ?
		RING_AW'(tail_sum - (RING_AW+1)'(RING_DEPTH)) : tail_sum[RING_AW-1:0];
	assign base     = half_q ? PLAY_AW'(HALF_LENGTH) : '0;

	// Memory ports driven from here
	assign ring_we = accept && (cmd == CMD_WRITE) && !ring_full;
	assign play_re = accept && (cmd == CMD_TICK);

	// Control state: sequencer, ring pointers, play position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			pos_q   <= '0;
			half_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_POST;
						if (cmd == CMD_WRITE) begin
							if (!ring_full) begin
								head_q <= head_nxt;
							end
						end else begin
							pos_q <= at_end ? '0 : pos_inc[PLAY_AW-1:0];
							if (refill) begin
								tail_q <= tail_new;
								half_q <= ~half_q;
							end
						end
					end
				end
				ST_POST: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the pending result and the refill request
	always_ff @(posedge clk) begin
		if (accept) begin
			res_tick_q <= (cmd == CMD_TICK);
			res_acc_q  <= (cmd == CMD_WRITE) && !ring_full;
			res_ref_q  <= (cmd == CMD_TICK) && refill;
			res_pad_q  <= (cmd == CMD_TICK) && refill && pad;
			req_base_q <= base;
			req_ptr_q  <= tail_q;
			req_cnt_q  <= drain;
		end
	end

	// Launch the refill as the tick's result leaves
	always_comb begin
		fill_req.start = out_load && res_ref_q;
		fill_req.base  = req_base_q;
		fill_req.ptr   = req_ptr_q;
		fill_req.cnt   = req_cnt_q;
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q     <= res_tick_q ? play_rdata : '0;
			write_accepted_q <= res_acc_q;
			half_refilled_q  <= res_ref_q;
			underrun_q       <= res_pad_q;
			ring_level_q     <= cnt_ext;
		end
	end

	assign out_valid      = out_valid_q;
	assign sample_out     = sample_out_q;
	assign write_accepted = write_accepted_q;
	assign half_refilled  = half_refilled_q;
	assign underrun       = underrun_q;
	assign ring_level     = ring_level_q;

	ardb_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ring_ram (
		.clk  (clk),
		.we   (ring_we),
		.waddr(head_q),
		.wdata(sample_in),
		.re   (ring_re),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	ardb_ram #(
		.WIDTH(8),
		.DEPTH(PLAY_LENGTH)
	) u_play_ram (
		.clk  (clk),
		.we   (play_we),
		.waddr(play_waddr),
		.wdata(play_wdata),
		.re   (play_re),
		.raddr(pos_q),
		.rdata(play_rdata)
	);

	ardb_refill u_refill (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (fill_req),
		.ring_rdata(ring_rdata),
		.busy      (fill_busy),
		.ring_re   (ring_re),
		.ring_raddr(ring_raddr),
		.play_we   (play_we),
		.play_waddr(play_waddr),
		.play_wdata(play_wdata)
	);

	`ARDB_ASSERT_IMP(a_no_ring_write_busy, clk, arst_n, ring_we, !fill_busy, "ring written during refill")
	`ARDB_ASSERT_NXT(a_accept_to_post, clk, arst_n, accept, state_q == ST_POST, "accepted word not posted")
	`ARDB_ASSERT_IMP(a_start_with_load, clk, arst_n, fill_req.start, out_load && res_ref_q, "refill launched without tick result")

endmodule
